// ===== rtl/ebaf_pkg.sv =====
// Package for the event background-activity filter.
// Holds shared constants, the controller state type and the command/status structs.
// No dependencies.
package ebaf_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W  = 8;
  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 24;

  // Default sensor geometry.
  localparam int SENSOR_WIDTH_DEF  = 240;
  localparam int SENSOR_HEIGHT_DEF = 180;

  // Support window after reset, in microseconds.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd30000;

  // Eight neighbors are written per interior event.
  localparam int NB_W = 3;
  localparam logic [NB_W-1:0] NB_LAST = 3'd7;

  // Neighbor codes, column offset first, then row offset.
  localparam logic [NB_W-1:0] NB_WEST_UP    = 3'd0;
  localparam logic [NB_W-1:0] NB_WEST       = 3'd1;
  localparam logic [NB_W-1:0] NB_WEST_DOWN  = 3'd2;
  localparam logic [NB_W-1:0] NB_UP         = 3'd3;
  localparam logic [NB_W-1:0] NB_DOWN       = 3'd4;
  localparam logic [NB_W-1:0] NB_EAST_UP    = 3'd5;
  localparam logic [NB_W-1:0] NB_EAST       = 3'd6;
  localparam logic [NB_W-1:0] NB_EAST_DOWN  = 3'd7;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_PUSH
  } ebaf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            accept;    // capture the incoming request
    logic            clear_wr;  // clear one valid bit and advance the sweep
    logic            mem_rd;    // read the event's own pixel
    logic            mem_wr;    // write one neighbor
    logic            eval;      // read data is ready, evaluate the window
    logic [NB_W-1:0] nb_sel;    // which neighbor to write
    logic            out_load;  // load the result register
  } ebaf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic oor;         // captured event lies off the sensor
    logic interior;    // captured event is off the border
    logic out_free;    // result register can take a new result
    logic clear_last;  // sweep is at the last pixel
  } ebaf_stat_t;

endpackage

// ===== rtl/ebaf_ctrl.sv =====
// Controller state machine of the event background-activity filter.
// Sequences the valid-map clearing sweep, lookup, neighbor writes and result push.
// Depends on ebaf_pkg.
module ebaf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ebaf_pkg::ebaf_stat_t   stat_i,
  output ebaf_pkg::ebaf_cmd_t    cmd_o
);

  ebaf_pkg::ebaf_state_e state_q, state_d;
  logic [ebaf_pkg::NB_W-1:0] cnt_q, cnt_d;

  // State and neighbor counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ebaf_pkg::ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ebaf_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ebaf_pkg::ST_IDLE;
        end
      end
      ebaf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ebaf_pkg::ST_LOOKUP;
        end
      end
      ebaf_pkg::ST_LOOKUP: begin
        // An off-sensor event touches no memory; it reports in lookup unless the result register is full.
        if (stat_i.oor) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ebaf_pkg::ST_IDLE;
          end else begin
            state_d = ebaf_pkg::ST_PUSH;
          end
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ebaf_pkg::ST_UPDATE;
        end
      end
      ebaf_pkg::ST_UPDATE: begin
        // The first update cycle evaluates the window while the first neighbor of an interior event is written.
        cmd_o.eval   = (cnt_q == '0);
        cmd_o.mem_wr = stat_i.interior;
        cmd_o.nb_sel = cnt_q;
        cnt_d        = cnt_q + 1'b1;
        if (!stat_i.interior || cnt_q == ebaf_pkg::NB_LAST) begin
          cnt_d = '0;
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ebaf_pkg::ST_IDLE;
          end else begin
            state_d = ebaf_pkg::ST_PUSH;
          end
        end
      end
      ebaf_pkg::ST_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ebaf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ebaf_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // The neighbor counter only runs during the update phase.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ebaf_pkg::ST_UPDATE |-> cnt_q == '0)
    else $error("neighbor counter nonzero outside update");

  // Neighbor writes happen only for interior, on-sensor events.
  a_wr_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> stat_i.interior && !stat_i.oor)
    else $error("neighbor write for a border or off-sensor event");

  // An accepted request always proceeds to the lookup.
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ebaf_pkg::ST_LOOKUP)
    else $error("accepted request did not enter lookup");

endmodule

// ===== rtl/ebaf_datapath.sv =====
// Datapath of the event background-activity filter: input capture, window register,
// pixel memories, clearing sweep, window compare and result register. Depends on ebaf_pkg.
module ebaf_datapath #(
  parameter int SENSOR_WIDTH  = ebaf_pkg::SENSOR_WIDTH_DEF,
  parameter int SENSOR_HEIGHT = ebaf_pkg::SENSOR_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ebaf_pkg::COORD_W-1:0]  pixel_x_i,
  input  logic [ebaf_pkg::COORD_W-1:0]  pixel_y_i,
  input  logic [ebaf_pkg::TIME_W-1:0]   time_us_i,
  input  logic                          cfg_we_i,
  input  logic [ebaf_pkg::WINDOW_W-1:0] cfg_wdata_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          passed_o,
  output logic                          out_of_range_o,
  input  ebaf_pkg::ebaf_cmd_t           cmd_i,
  output ebaf_pkg::ebaf_stat_t          stat_o
);

  localparam int PIXELS = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam int IDX_W  = 2 * ebaf_pkg::COORD_W;
  localparam logic [ADDR_W-1:0] H_A    = ADDR_W'(SENSOR_HEIGHT);
  localparam logic [ADDR_W-1:0] ONE_A  = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(PIXELS - 1);

  // Pixel memories, column-major: index = column * height + row.
  logic [ebaf_pkg::TIME_W-1:0] time_mem [PIXELS];
  logic                        valid_mem [PIXELS];

  logic [ebaf_pkg::WINDOW_W-1:0] window_q;
  logic [ADDR_W-1:0]             clr_addr_q;
  logic [ADDR_W-1:0]             idx_q;
  logic [ebaf_pkg::TIME_W-1:0]   time_q;
  logic                          oor_q;
  logic                          interior_q;
  logic [ebaf_pkg::TIME_W-1:0]   time_rd_q;
  logic                          valid_rd_q;
  logic                          pass_q;
  logic                          out_valid_q;
  logic                          passed_q;
  logic                          out_of_range_q;

  logic [IDX_W-1:0]            idx_full;
  logic                        oor_d;
  logic                        interior_d;
  logic [ADDR_W-1:0]           nb_addr;
  logic [ebaf_pkg::TIME_W-1:0] delta;
  logic                        in_window;
  logic                        pass_sel;
  logic                        out_free;

  // Pixel index and geometry checks of the incoming request.
  always_comb begin
    idx_full = IDX_W'(pixel_x_i) * IDX_W'(SENSOR_HEIGHT) + IDX_W'(pixel_y_i);
    oor_d    = (pixel_x_i >= ebaf_pkg::COORD_W'(SENSOR_WIDTH)) ||
               (pixel_y_i >= ebaf_pkg::COORD_W'(SENSOR_HEIGHT));
    interior_d = (pixel_x_i != '0) && (pixel_x_i < ebaf_pkg::COORD_W'(SENSOR_WIDTH - 1)) &&
                 (pixel_y_i != '0) && (pixel_y_i < ebaf_pkg::COORD_W'(SENSOR_HEIGHT - 1));
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q      <= idx_full[ADDR_W-1:0];
      time_q     <= time_us_i;
      oor_q      <= oor_d;
      interior_q <= interior_d;
    end
  end

  // Support window register and clearing sweep address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= ebaf_pkg::WINDOW_RESET;
      clr_addr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_wr) begin
        clr_addr_q <= clr_addr_q + ONE_A;
      end
    end
  end

  // Neighbor address relative to the event's own pixel.
  always_comb begin
    case (cmd_i.nb_sel)
      ebaf_pkg::NB_WEST_UP:   nb_addr = idx_q - H_A - ONE_A;
      ebaf_pkg::NB_WEST:      nb_addr = idx_q - H_A;
      ebaf_pkg::NB_WEST_DOWN: nb_addr = idx_q - H_A + ONE_A;
      ebaf_pkg::NB_UP:        nb_addr = idx_q - ONE_A;
      ebaf_pkg::NB_DOWN:      nb_addr = idx_q + ONE_A;
      ebaf_pkg::NB_EAST_UP:   nb_addr = idx_q + H_A - ONE_A;
      ebaf_pkg::NB_EAST:      nb_addr = idx_q + H_A;
      ebaf_pkg::NB_EAST_DOWN: nb_addr = idx_q + H_A + ONE_A;
      default:                nb_addr = idx_q;
    endcase
  end

  // Support time memory, one access per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      time_mem[nb_addr] <= time_q;
    end else if (cmd_i.mem_rd) begin
      time_rd_q <= time_mem[idx_q];
    end
  end

  // Valid map, cleared by the sweep after reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_wr) begin
      valid_mem[clr_addr_q] <= 1'b0;
    end else if (cmd_i.mem_wr) begin
      valid_mem[nb_addr] <= 1'b1;
    end else if (cmd_i.mem_rd) begin
      valid_rd_q <= valid_mem[idx_q];
    end
  end

  // Window compare on the wrapping time difference.
  always_comb begin
    delta     = time_q - time_rd_q;
    in_window = valid_rd_q && (delta < ebaf_pkg::TIME_W'(window_q));
    pass_sel  = cmd_i.eval ? in_window : pass_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      pass_q <= in_window;
    end
  end

  // Result register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      passed_q       <= !oor_q && pass_sel;
      out_of_range_q <= oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign passed_o       = passed_q;
  assign out_of_range_o = out_of_range_q;

  // Status toward the controller.
  always_comb begin
    stat_o.oor        = oor_q;
    stat_o.interior   = interior_q;
    stat_o.out_free   = out_free;
    stat_o.clear_last = (clr_addr_q == LAST_A);
  end

  // An off-sensor event is never reported as passed.
  a_oor_not_passed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_of_range_q |-> !passed_q)
    else $error("off-sensor event reported as passed");

  // The clearing sweep owns the memories while it runs.
  a_clear_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_wr |-> !cmd_i.mem_wr && !cmd_i.mem_rd && !cmd_i.accept)
    else $error("memory access during clearing sweep");

endmodule

// ===== rtl/event_background_activity_filter.sv =====
// Top level of the event background-activity filter.
// A request is accepted only in idle. It then passes the lookup, which reads the event's
// own pixel, and the update, which writes the eight neighbors of an interior pixel on one
// port; border pixels skip the writes, off-sensor events skip the read and the writes.
// A stalled, full result register holds the block in push. Input stays stalled until then.
// Reset: a sweep over all SENSOR_WIDTH*SENSOR_HEIGHT pixels (43200 by default) clears the valid
// map; input is stalled during it, configuration writes are taken. Depends on ebaf_pkg.
module event_background_activity_filter #(
  parameter int SENSOR_WIDTH  = ebaf_pkg::SENSOR_WIDTH_DEF,
  parameter int SENSOR_HEIGHT = ebaf_pkg::SENSOR_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ebaf_pkg::COORD_W-1:0]  pixel_x_i,
  input  logic [ebaf_pkg::COORD_W-1:0]  pixel_y_i,
  input  logic [ebaf_pkg::TIME_W-1:0]   time_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          passed_o,
  output logic                          out_of_range_o,
  input  logic                          cfg_we_i,
  input  logic [ebaf_pkg::WINDOW_W-1:0] cfg_wdata_i
);

  ebaf_pkg::ebaf_cmd_t  cmd;
  ebaf_pkg::ebaf_stat_t stat;

  // Sequencing.
  ebaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  ebaf_datapath #(
    .SENSOR_WIDTH  (SENSOR_WIDTH),
    .SENSOR_HEIGHT (SENSOR_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .time_us_i      (time_us_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .passed_o       (passed_o),
    .out_of_range_o (out_of_range_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule
